// File: rtl/qrm_pkg.sv
// ----------------------------------------------------------------------------
// qrm_pkg
// types and constants shared by the quaternion to rotation matrix pipeline
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int COMP_W       = 16;
    localparam int RESULT_W     = 16;
    localparam int FRAC_BITS    = 14;
    localparam int PROD_W       = 2 * COMP_W;
    localparam int N_W          = PROD_W + 1;
    localparam int NUM_W        = PROD_W + 2;
    localparam int MAG_W        = PROD_W + 1;
    localparam int QUO_STEPS    = FRAC_BITS + 1;
    localparam int DIV_STEPS    = QUO_STEPS + 1;
    localparam int QUO_W        = RESULT_W;
    localparam int NUM_ENTRIES  = 9;
    localparam int FRONT_STAGES = 4;

    localparam int ENT_00 = 0;
    localparam int ENT_01 = 1;
    localparam int ENT_02 = 2;
    localparam int ENT_10 = 3;
    localparam int ENT_11 = 4;
    localparam int ENT_12 = 5;
    localparam int ENT_20 = 6;
    localparam int ENT_21 = 7;
    localparam int ENT_22 = 8;

    typedef logic signed [COMP_W-1:0]   comp_t;
    typedef logic signed [RESULT_W-1:0] entry_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [NUM_W-1:0]    num_t;
    typedef logic [N_W-1:0]             norm_t;
    typedef logic [MAG_W-1:0]           mag_t;
    typedef logic [QUO_W-1:0]           quo_t;

    localparam entry_t Q_ONE   = entry_t'(1 << FRAC_BITS);
    localparam entry_t SAT_MAX = entry_t'((1 << (RESULT_W - 1)) - 1);

    typedef struct packed {
        comp_t quat_x;
        comp_t quat_y;
        comp_t quat_z;
        comp_t quat_w;
    } quat_t;

    typedef struct packed {
        entry_t rot_00;
        entry_t rot_01;
        entry_t rot_02;
        entry_t rot_10;
        entry_t rot_11;
        entry_t rot_12;
        entry_t rot_20;
        entry_t rot_21;
        entry_t rot_22;
        logic   degenerate;
    } rot_t;

    // numerator magnitudes and signs over the shared norm
    typedef struct packed {
        norm_t                        norm;
        logic [NUM_ENTRIES-1:0]       neg;
        logic [NUM_ENTRIES-1:0][MAG_W-1:0] mag;
        logic                         degen;
    } ratio_t;

endpackage

// File: rtl/qrm_quat_if.sv
// ----------------------------------------------------------------------------
// qrm_quat_if
// valid/ready channel carrying one quaternion per transfer
// ----------------------------------------------------------------------------
interface qrm_quat_if;

    logic           valid;
    logic           ready;
    qrm_pkg::quat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// File: rtl/qrm_rot_if.sv
// ----------------------------------------------------------------------------
// qrm_rot_if
// valid/ready channel carrying one rotation matrix per transfer
// ----------------------------------------------------------------------------
interface qrm_rot_if;

    logic          valid;
    logic          ready;
    qrm_pkg::rot_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// File: rtl/qrm_div_lane.sv
// ----------------------------------------------------------------------------
// qrm_div_lane
// pipelined restoring divider, one quotient bit per stage, rounding last
// ----------------------------------------------------------------------------
module qrm_div_lane (
    input  logic                                         clk,
    input  logic [qrm_pkg::DIV_STEPS-1:0]                stage_en,
    input  qrm_pkg::mag_t                                mag,
    input  logic                                         neg,
    input  logic [qrm_pkg::DIV_STEPS-1:0][qrm_pkg::N_W-1:0] n_feed,
    output qrm_pkg::quo_t                                quo,
    output logic                                         quo_neg
);

    localparam int N_W       = qrm_pkg::N_W;
    localparam int QUO_W     = qrm_pkg::QUO_W;
    localparam int QUO_STEPS = qrm_pkg::QUO_STEPS;
    localparam int DIV_STEPS = qrm_pkg::DIV_STEPS;

    logic [N_W-1:0] rem_reg [QUO_STEPS];
    qrm_pkg::quo_t  quo_reg [DIV_STEPS];
    logic           neg_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [N_W:0] trial;
        logic         fits;

        assign fits = trial >= {1'b0, n_feed[k]};

        if (k == 0)
        begin : g_first
            logic [N_W:0] diff;

            assign trial = {1'b0, mag};
            assign diff  = trial - {1'b0, n_feed[k]};

            always_ff @(posedge clk)
            begin
                if (stage_en[k])
                begin
                    rem_reg[k] <= fits ? diff[N_W-1:0] : trial[N_W-1:0];
                    quo_reg[k] <= qrm_pkg::quo_t'(fits);
                    neg_reg[k] <= neg;
                end
            end
        end
        else if (k < QUO_STEPS)
        begin : g_mid
            logic [N_W:0] diff;

            assign trial = {rem_reg[k-1], 1'b0};
            assign diff  = trial - {1'b0, n_feed[k]};

            always_ff @(posedge clk)
            begin
                if (stage_en[k])
                begin
                    rem_reg[k] <= fits ? diff[N_W-1:0] : trial[N_W-1:0];
                    quo_reg[k] <= {quo_reg[k-1][QUO_W-2:0], fits};
                    neg_reg[k] <= neg_reg[k-1];
                end
            end
        end
        else
        begin : g_round
            // round half away from zero on the magnitude
            assign trial = {rem_reg[k-1], 1'b0};

            always_ff @(posedge clk)
            begin
                if (stage_en[k])
                begin
                    quo_reg[k] <= quo_reg[k-1] + qrm_pkg::quo_t'(fits);
                    neg_reg[k] <= neg_reg[k-1];
                end
            end
        end
    end

    assign quo     = quo_reg[DIV_STEPS-1];
    assign quo_neg = neg_reg[DIV_STEPS-1];

endmodule

// File: rtl/qrm_front.sv
// ----------------------------------------------------------------------------
// qrm_front
// input register, component products, numerator sums and magnitudes
// ----------------------------------------------------------------------------
module qrm_front (
    input  logic            clk,
    input  logic            rst_n,
    qrm_quat_if.sink        quat,
    output logic            out_valid,
    input  logic            out_ready,
    output qrm_pkg::ratio_t out_data
);

    localparam int STAGES  = qrm_pkg::FRONT_STAGES;
    localparam int ST_IN   = 0;
    localparam int ST_PROD = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_MAG  = 3;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] stage_en;

    qrm_pkg::quat_t  quat_reg;
    qrm_pkg::prod_t  xx_reg, yy_reg, zz_reg, ww_reg;
    qrm_pkg::prod_t  xy_reg, xz_reg, yz_reg, xw_reg, yw_reg, zw_reg;
    qrm_pkg::num_t   xx_e, yy_e, zz_e, ww_e, xy_e, xz_e, yz_e, xw_e, yw_e, zw_e;
    qrm_pkg::norm_t  norm_next, norm_reg;
    qrm_pkg::num_t   num_next [qrm_pkg::NUM_ENTRIES];
    qrm_pkg::num_t   num_reg [qrm_pkg::NUM_ENTRIES];
    qrm_pkg::ratio_t ratio_next, ratio_reg;

    assign stage_en[ST_MAG]  = !valid_reg[ST_MAG] || out_ready;
    assign stage_en[ST_SUM]  = !valid_reg[ST_SUM] || stage_en[ST_MAG];
    assign stage_en[ST_PROD] = !valid_reg[ST_PROD] || stage_en[ST_SUM];
    assign stage_en[ST_IN]   = !valid_reg[ST_IN] || stage_en[ST_PROD];

    assign quat.ready = stage_en[ST_IN];
    assign out_valid  = valid_reg[ST_MAG];
    assign out_data   = ratio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[ST_IN])   valid_reg[ST_IN]   <= quat.valid;
            if (stage_en[ST_PROD]) valid_reg[ST_PROD] <= valid_reg[ST_IN];
            if (stage_en[ST_SUM])  valid_reg[ST_SUM]  <= valid_reg[ST_PROD];
            if (stage_en[ST_MAG])  valid_reg[ST_MAG]  <= valid_reg[ST_SUM];
        end
    end

    // products, sign extended for the sums
    assign xx_e = qrm_pkg::num_t'(xx_reg);
    assign yy_e = qrm_pkg::num_t'(yy_reg);
    assign zz_e = qrm_pkg::num_t'(zz_reg);
    assign ww_e = qrm_pkg::num_t'(ww_reg);
    assign xy_e = qrm_pkg::num_t'(xy_reg);
    assign xz_e = qrm_pkg::num_t'(xz_reg);
    assign yz_e = qrm_pkg::num_t'(yz_reg);
    assign xw_e = qrm_pkg::num_t'(xw_reg);
    assign yw_e = qrm_pkg::num_t'(yw_reg);
    assign zw_e = qrm_pkg::num_t'(zw_reg);

    always_comb
    begin
        norm_next = qrm_pkg::norm_t'(xx_e + yy_e + zz_e + ww_e);
        num_next[qrm_pkg::ENT_00] = xx_e + ww_e - yy_e - zz_e;
        num_next[qrm_pkg::ENT_11] = yy_e + ww_e - xx_e - zz_e;
        num_next[qrm_pkg::ENT_22] = zz_e + ww_e - xx_e - yy_e;
        num_next[qrm_pkg::ENT_01] = (xy_e - zw_e) <<< 1;
        num_next[qrm_pkg::ENT_10] = (xy_e + zw_e) <<< 1;
        num_next[qrm_pkg::ENT_02] = (xz_e + yw_e) <<< 1;
        num_next[qrm_pkg::ENT_20] = (xz_e - yw_e) <<< 1;
        num_next[qrm_pkg::ENT_12] = (yz_e - xw_e) <<< 1;
        num_next[qrm_pkg::ENT_21] = (yz_e + xw_e) <<< 1;
    end

    always_comb
    begin
        ratio_next.norm  = norm_reg;
        ratio_next.degen = (norm_reg == '0);
        for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++)
        begin
            ratio_next.neg[i] = num_reg[i][qrm_pkg::NUM_W-1];
            ratio_next.mag[i] = num_reg[i][qrm_pkg::NUM_W-1]
                              ? qrm_pkg::mag_t'(-num_reg[i])
                              : qrm_pkg::mag_t'(num_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_IN])
        begin
            quat_reg <= quat.data;
        end
        if (stage_en[ST_PROD])
        begin
            xx_reg <= qrm_pkg::prod_t'(quat_reg.quat_x) * qrm_pkg::prod_t'(quat_reg.quat_x);
            yy_reg <= qrm_pkg::prod_t'(quat_reg.quat_y) * qrm_pkg::prod_t'(quat_reg.quat_y);
            zz_reg <= qrm_pkg::prod_t'(quat_reg.quat_z) * qrm_pkg::prod_t'(quat_reg.quat_z);
            ww_reg <= qrm_pkg::prod_t'(quat_reg.quat_w) * qrm_pkg::prod_t'(quat_reg.quat_w);
            xy_reg <= qrm_pkg::prod_t'(quat_reg.quat_x) * qrm_pkg::prod_t'(quat_reg.quat_y);
            xz_reg <= qrm_pkg::prod_t'(quat_reg.quat_x) * qrm_pkg::prod_t'(quat_reg.quat_z);
            yz_reg <= qrm_pkg::prod_t'(quat_reg.quat_y) * qrm_pkg::prod_t'(quat_reg.quat_z);
            xw_reg <= qrm_pkg::prod_t'(quat_reg.quat_x) * qrm_pkg::prod_t'(quat_reg.quat_w);
            yw_reg <= qrm_pkg::prod_t'(quat_reg.quat_y) * qrm_pkg::prod_t'(quat_reg.quat_w);
            zw_reg <= qrm_pkg::prod_t'(quat_reg.quat_z) * qrm_pkg::prod_t'(quat_reg.quat_w);
        end
        if (stage_en[ST_SUM])
        begin
            norm_reg <= norm_next;
            num_reg  <= num_next;
        end
        if (stage_en[ST_MAG])
        begin
            ratio_reg <= ratio_next;
        end
    end

endmodule

// File: rtl/qrm_back.sv
// ----------------------------------------------------------------------------
// qrm_back
// nine divider lanes sharing the norm, sign and saturation, output register
// ----------------------------------------------------------------------------
module qrm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  qrm_pkg::ratio_t in_data,
    qrm_rot_if.source       rot
);

    localparam int DIV_STEPS   = qrm_pkg::DIV_STEPS;
    localparam int QUO_STEPS   = qrm_pkg::QUO_STEPS;
    localparam int QUO_W       = qrm_pkg::QUO_W;
    localparam int N_W         = qrm_pkg::N_W;
    localparam int NUM_ENTRIES = qrm_pkg::NUM_ENTRIES;
    localparam int STAGES      = DIV_STEPS + 1;
    localparam int OUT_STAGE   = DIV_STEPS;

    logic [STAGES-1:0]              valid_reg;
    logic [STAGES-1:0]              stage_en;
    logic [DIV_STEPS-1:0][N_W-1:0]  n_feed;
    qrm_pkg::norm_t                 norm_reg [QUO_STEPS];
    logic                           degen_reg [DIV_STEPS];
    qrm_pkg::quo_t                  lane_quo [NUM_ENTRIES];
    logic                           lane_neg [NUM_ENTRIES];
    qrm_pkg::entry_t                entry_next [NUM_ENTRIES];
    qrm_pkg::rot_t                  rot_next, rot_reg;

    always_comb
    begin
        stage_en[OUT_STAGE] = !valid_reg[OUT_STAGE] || rot.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign in_ready  = stage_en[0];
    assign rot.valid = valid_reg[OUT_STAGE];
    assign rot.data  = rot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0]) valid_reg[0] <= in_valid;
            for (int k = 1; k < STAGES; k++)
            begin
                if (stage_en[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // norm as seen by each divider step
    always_comb
    begin
        n_feed[0] = in_data.norm;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            n_feed[k] = norm_reg[k-1];
        end
    end

    for (genvar k = 0; k < QUO_STEPS; k++)
    begin : g_norm
        always_ff @(posedge clk)
        begin
            if (stage_en[k]) norm_reg[k] <= n_feed[k];
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_degen
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (stage_en[k]) degen_reg[k] <= in_data.degen;
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (stage_en[k]) degen_reg[k] <= degen_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < NUM_ENTRIES; i++)
    begin : g_lane
        localparam bit IS_DIAG = (i == qrm_pkg::ENT_00) || (i == qrm_pkg::ENT_11)
                              || (i == qrm_pkg::ENT_22);

        qrm_div_lane u_lane (
            .clk      (clk),
            .stage_en (stage_en[DIV_STEPS-1:0]),
            .mag      (in_data.mag[i]),
            .neg      (in_data.neg[i]),
            .n_feed   (n_feed),
            .quo      (lane_quo[i]),
            .quo_neg  (lane_neg[i])
        );

        always_comb
        begin
            if (degen_reg[DIV_STEPS-1])
                entry_next[i] = IS_DIAG ? qrm_pkg::Q_ONE : '0;
            else if (lane_neg[i])
                entry_next[i] = qrm_pkg::entry_t'(~lane_quo[i] + qrm_pkg::quo_t'(1));
            else if (lane_quo[i][QUO_W-1])
                entry_next[i] = qrm_pkg::SAT_MAX;
            else
                entry_next[i] = qrm_pkg::entry_t'(lane_quo[i]);
        end
    end

    always_comb
    begin
        rot_next.rot_00     = entry_next[qrm_pkg::ENT_00];
        rot_next.rot_01     = entry_next[qrm_pkg::ENT_01];
        rot_next.rot_02     = entry_next[qrm_pkg::ENT_02];
        rot_next.rot_10     = entry_next[qrm_pkg::ENT_10];
        rot_next.rot_11     = entry_next[qrm_pkg::ENT_11];
        rot_next.rot_12     = entry_next[qrm_pkg::ENT_12];
        rot_next.rot_20     = entry_next[qrm_pkg::ENT_20];
        rot_next.rot_21     = entry_next[qrm_pkg::ENT_21];
        rot_next.rot_22     = entry_next[qrm_pkg::ENT_22];
        rot_next.degenerate = degen_reg[DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[OUT_STAGE]) rot_reg <= rot_next;
    end

endmodule

// File: rtl/quaternion_to_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_core
// Takes one quaternion per transfer and returns the nine entries of its
// normalized 3x3 rotation matrix in signed Q1.14, rounded to nearest and
// saturated; an all-zero quaternion gives the identity with degenerate set.
// One quaternion is taken every cycle when nothing stalls, and each one passes
// to rot through these stages in order: four stages form the
// products and numerators, sixteen stages hold the nine restoring dividers
// (one quotient bit per stage plus a rounding step against the shared norm),
// and one output register applies sign and saturation. Backpressure on rot
// only holds items back where the pipeline is full; empty stages close up.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_core (
    input  logic      clk,
    input  logic      rst_n,
    qrm_quat_if.sink  quat,
    qrm_rot_if.source rot
);

    logic            mid_valid;
    logic            mid_ready;
    qrm_pkg::ratio_t mid_data;
    logic            entries_ok;

    function automatic logic unit_range(input qrm_pkg::entry_t v);
        return (v >= -qrm_pkg::Q_ONE) && (v <= qrm_pkg::Q_ONE);
    endfunction

    qrm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .quat      (quat),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_data  (mid_data)
    );

    qrm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mid_valid),
        .in_ready (mid_ready),
        .in_data  (mid_data),
        .rot      (rot)
    );

    assign entries_ok = unit_range(rot.data.rot_00) && unit_range(rot.data.rot_01)
                     && unit_range(rot.data.rot_02) && unit_range(rot.data.rot_10)
                     && unit_range(rot.data.rot_11) && unit_range(rot.data.rot_12)
                     && unit_range(rot.data.rot_20) && unit_range(rot.data.rot_21)
                     && unit_range(rot.data.rot_22);

    a_degen_identity: assert property (@(posedge clk) disable iff (!rst_n)
        rot.valid && rot.data.degenerate |->
            (rot.data.rot_00 == qrm_pkg::Q_ONE) && (rot.data.rot_11 == qrm_pkg::Q_ONE)
            && (rot.data.rot_22 == qrm_pkg::Q_ONE) && (rot.data.rot_01 == '0)
            && (rot.data.rot_02 == '0) && (rot.data.rot_10 == '0)
            && (rot.data.rot_12 == '0) && (rot.data.rot_20 == '0)
            && (rot.data.rot_21 == '0))
        else $error("degenerate transfer without identity matrix");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        rot.valid |-> entries_ok)
        else $error("rotation entry outside unit range");

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        rot.ready |-> quat.ready)
        else $error("input stalled while output is ready");

endmodule
